[hw/rtl/voxel_face_mesher_with_ao_macros.svh]
// Assertion macros used by the voxel face mesher checker.
`ifndef VOXEL_FACE_MESHER_WITH_AO_MACROS_SVH
`define VOXEL_FACE_MESHER_WITH_AO_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define VFM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define VFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/vfm_pkg.sv]
// Types, constants and face tables shared by the voxel face mesher.
`timescale 1ns / 1ps
`default_nettype none
package vfm_pkg;

  localparam int ChunkSizeDef  = 16;
  localparam int QueueDepthDef = 2;
  localparam int NumFaces      = 6;

  typedef enum logic [0:0] {
    RegTexturesOn     = 1'b0,
    RegMultiTextureOn = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    FacePosZ = 3'd0,
    FaceNegZ = 3'd1,
    FaceNegX = 3'd2,
    FacePosX = 3'd3,
    FaceNegY = 3'd4,
    FacePosY = 3'd5
  } face_e;

  typedef struct packed {
    logic textures_on;
    logic multi_texture_on;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  vx;
    logic [3:0]  vy;
    logic [3:0]  vz;
    logic [26:0] nb;
    logic [23:0] rgb;
    logic [2:0]  tile_x;
    logic [2:0]  tile_y;
    logic [5:0]  open;
  } job_t;

  typedef struct packed {
    logic [4:0]  corner_x;
    logic [4:0]  corner_y;
    logic [4:0]  corner_z;
    logic [17:0] fixed_pos;
    logic [23:0] shade_color;
    logic [7:0]  shading;
    logic [2:0]  face;
    logic [7:0]  ao_u;
    logic [7:0]  ao_v;
    logic [3:0]  tex_u;
    logic [3:0]  tex_v;
    logic        last;
  } vert_t;

  localparam logic [7:0] HealthLimit = 8'd100;
  localparam logic [3:0] TexFull     = 4'd8;
  localparam logic [3:0] AoFar       = 4'hf;

  localparam logic signed [1:0] P1 = 2'sb01;
  localparam logic signed [1:0] Z0 = 2'sb00;
  localparam logic signed [1:0] M1 = 2'sb11;

  // Per face: base offset, normal, u axis, v axis (x, y, z each).
  localparam logic signed [1:0] FaceGeom [NumFaces][12] = '{
    '{P1, Z0, P1,  Z0, Z0, P1,  M1, Z0, Z0,  Z0, P1, Z0},
    '{Z0, Z0, Z0,  Z0, Z0, M1,  P1, Z0, Z0,  Z0, P1, Z0},
    '{Z0, P1, Z0,  M1, Z0, Z0,  Z0, Z0, P1,  Z0, M1, Z0},
    '{P1, Z0, Z0,  P1, Z0, Z0,  Z0, Z0, P1,  Z0, P1, Z0},
    '{Z0, Z0, Z0,  Z0, M1, Z0,  Z0, Z0, P1,  P1, Z0, Z0},
    '{P1, P1, Z0,  Z0, P1, Z0,  Z0, Z0, P1,  M1, Z0, Z0}
  };

  // Neighbourhood bit of the cell in front of each face.
  localparam logic [4:0] NormalBit [NumFaces] = '{5'd22, 5'd4, 5'd12, 5'd14, 5'd10, 5'd16};

  localparam logic [7:0] FaceShade [NumFaces] = '{8'd0, 8'd220, 8'd0, 8'd0, 8'd255, 8'd0};

endpackage
`default_nettype wire

[hw/rtl/vfm_ifs.sv]
// Valid/ready channel interfaces for voxel words and vertex words.
`timescale 1ns / 1ps
`default_nettype none
interface vfm_vox_if;
  logic        valid;
  logic        ready;
  logic [3:0]  voxel_x;
  logic [3:0]  voxel_y;
  logic [3:0]  voxel_z;
  logic [26:0] neighbourhood;
  logic [31:0] voxel_color;

  modport source (output valid, voxel_x, voxel_y, voxel_z, neighbourhood, voxel_color,
                  input ready);
  modport sink (input valid, voxel_x, voxel_y, voxel_z, neighbourhood, voxel_color,
                output ready);
endinterface

interface vfm_vert_if;
  logic        valid;
  logic        ready;
  logic [4:0]  corner_x;
  logic [4:0]  corner_y;
  logic [4:0]  corner_z;
  logic [17:0] fixed_pos;
  logic [23:0] shade_color;
  logic [7:0]  shading;
  logic [2:0]  face;
  logic [7:0]  ao_u;
  logic [7:0]  ao_v;
  logic [3:0]  tex_u;
  logic [3:0]  tex_v;
  logic        last;

  modport source (output valid, corner_x, corner_y, corner_z, fixed_pos, shade_color,
                  shading, face, ao_u, ao_v, tex_u, tex_v, last, input ready);
  modport sink (input valid, corner_x, corner_y, corner_z, fixed_pos, shade_color,
                shading, face, ao_u, ao_v, tex_u, tex_v, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/vfm_front.sv]
// Front end: accepts voxel words, culls them and builds a face job.
`timescale 1ns / 1ps
`default_nettype none
module vfm_front #(
  parameter int ChunkSize = vfm_pkg::ChunkSizeDef
) (
  vfm_vox_if.sink         vox,
  input  logic            full_i,
  output logic            push_o,
  output vfm_pkg::job_t   job_o
);

  logic       in_chunk;
  logic [1:0] blue_q4;
  logic [5:0] open;
  logic [23:0] rgb;

  always_comb begin
    for (int f = 0; f < vfm_pkg::NumFaces; f++) begin
      open[f] = ~vox.neighbourhood[vfm_pkg::NormalBit[f]];
    end
  end

  assign in_chunk = ({1'b0, vox.voxel_x} < 5'(ChunkSize)) &&
                    ({1'b0, vox.voxel_y} < 5'(ChunkSize)) &&
                    ({1'b0, vox.voxel_z} < 5'(ChunkSize));

  assign blue_q4 = vox.voxel_color[23:22];

  // Damaged voxels get every color channel halved.
  assign rgb = (vox.voxel_color[31:24] < vfm_pkg::HealthLimit) ?
               {1'b0, vox.voxel_color[23:17], 1'b0, vox.voxel_color[15:9],
                1'b0, vox.voxel_color[7:1]} :
               vox.voxel_color[23:0];

  assign vox.ready = ~full_i;
  assign push_o    = vox.valid && ~full_i && in_chunk && vox.neighbourhood[13] && (|open);

  always_comb begin
    job_o.vx     = vox.voxel_x;
    job_o.vy     = vox.voxel_y;
    job_o.vz     = vox.voxel_z;
    job_o.nb     = vox.neighbourhood;
    job_o.rgb    = rgb;
    job_o.tile_x = {blue_q4[0], vox.voxel_color[7:6]};
    job_o.tile_y = {blue_q4[1], vox.voxel_color[15:14]};
    job_o.open   = open;
  end

endmodule
`default_nettype wire

[hw/rtl/vfm_queue.sv]
// Short job queue between the front end and the vertex generator.
`timescale 1ns / 1ps
`default_nettype none
module vfm_queue #(
  parameter int Depth = vfm_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vfm_pkg::job_t wdata_i,
  output logic          full_o,
  output logic          valid_o,
  output vfm_pkg::job_t rdata_o,
  input  logic          pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  vfm_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/vfm_back.sv]
// Back end: walks the open faces of a job and emits one vertex word per cycle while the sink is ready.
`timescale 1ns / 1ps
`default_nettype none
module vfm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vfm_pkg::cfg_t  cfg_i,
  input  logic           job_valid_i,
  input  vfm_pkg::job_t  job_i,
  output logic           pop_o,
  vfm_vert_if.source     vert
);

  function automatic logic [4:0] corner_axis(logic [3:0] vc, logic signed [1:0] b,
                                             logic signed [1:0] u, logic signed [1:0] w,
                                             logic du, logic dv);
    logic [5:0] s;
    s = {2'b00, vc} + {{4{b[1]}}, b} + (du ? {{4{u[1]}}, u} : 6'd0) +
        (dv ? {{4{w[1]}}, w} : 6'd0);
    return s[4:0];
  endfunction

  function automatic logic [5:0] fixed_axis(logic [3:0] vc, logic signed [1:0] b,
                                            logic signed [1:0] u, logic signed [1:0] w);
    logic [6:0] s;
    s = {2'b00, vc, 1'b0} + {{4{b[1]}}, b, 1'b0} + {{5{u[1]}}, u} + {{5{w[1]}}, w};
    return s[5:0];
  endfunction

  function automatic logic cell_at(logic [26:0] nb, logic [2:0] dx, logic [2:0] dy,
                                   logic [2:0] dz);
    logic signed [6:0] idx;
    idx = {{4{dx[2]}}, dx} + 7'd1 + 7'd3 * ({{4{dy[2]}}, dy} + 7'd1) +
          7'd9 * ({{4{dz[2]}}, dz} + 7'd1);
    if (idx < 7'sd0 || idx > 7'sd26) begin
      return 1'b0;
    end
    return nb[idx[4:0]];
  endfunction

  vfm_pkg::job_t  job_q, job_d;
  vfm_pkg::vert_t out_q, out_d, vert_c;
  logic [5:0]     rem_q, rem_d;
  logic [1:0]     k_q, k_d;
  logic           act_q, act_d;
  logic           out_valid_q, out_valid_d;
  logic           adv;
  logic [5:0]     low_bit, rem_left;
  logic [2:0]     fidx;
  logic signed [1:0] g [12];
  logic [2:0]     n3 [3];
  logic [2:0]     u3 [3];
  logic [2:0]     w3 [3];
  logic [7:0]     ao_id;
  logic           du, dv;

  assign low_bit  = rem_q & (~rem_q + 6'd1);
  assign rem_left = rem_q & ~low_bit;
  assign du       = k_q[0];
  assign dv       = k_q[1];

  always_comb begin
    fidx = vfm_pkg::FacePosZ;
    for (int i = 0; i < vfm_pkg::NumFaces; i++) begin
      if (low_bit[i]) begin
        fidx = 3'(i);
      end
    end
  end

  always_comb begin
    g = vfm_pkg::FaceGeom[fidx];
    for (int a = 0; a < 3; a++) begin
      n3[a] = {g[3+a][1], g[3+a]};
      u3[a] = {g[6+a][1], g[6+a]};
      w3[a] = {g[9+a][1], g[9+a]};
    end
  end

  // Occlusion mask of the eight cells around the cell in front of the face.
  always_comb begin
    ao_id[0] = cell_at(job_q.nb, n3[0] - u3[0], n3[1] - u3[1], n3[2] - u3[2]);
    ao_id[1] = cell_at(job_q.nb, n3[0] + u3[0], n3[1] + u3[1], n3[2] + u3[2]);
    ao_id[2] = cell_at(job_q.nb, n3[0] - w3[0], n3[1] - w3[1], n3[2] - w3[2]);
    ao_id[3] = cell_at(job_q.nb, n3[0] + w3[0], n3[1] + w3[1], n3[2] + w3[2]);
    ao_id[4] = cell_at(job_q.nb, n3[0] - u3[0] + w3[0], n3[1] - u3[1] + w3[1],
                       n3[2] - u3[2] + w3[2]);
    ao_id[5] = cell_at(job_q.nb, n3[0] - u3[0] - w3[0], n3[1] - u3[1] - w3[1],
                       n3[2] - u3[2] - w3[2]);
    ao_id[6] = cell_at(job_q.nb, n3[0] + u3[0] + w3[0], n3[1] + u3[1] + w3[1],
                       n3[2] + u3[2] + w3[2]);
    ao_id[7] = cell_at(job_q.nb, n3[0] + u3[0] - w3[0], n3[1] + u3[1] - w3[1],
                       n3[2] + u3[2] - w3[2]);
  end

  always_comb begin
    vert_c.corner_x    = corner_axis(job_q.vx, g[0], g[6], g[9], du, dv);
    vert_c.corner_y    = corner_axis(job_q.vy, g[1], g[7], g[10], du, dv);
    vert_c.corner_z    = corner_axis(job_q.vz, g[2], g[8], g[11], du, dv);
    vert_c.fixed_pos   = {fixed_axis(job_q.vz, g[2], g[8], g[11]),
                          fixed_axis(job_q.vy, g[1], g[7], g[10]),
                          fixed_axis(job_q.vx, g[0], g[6], g[9])};
    vert_c.shade_color = job_q.rgb;
    vert_c.shading     = vfm_pkg::FaceShade[fidx];
    vert_c.face        = fidx;
    vert_c.ao_u        = {ao_id[3:0], du ? vfm_pkg::AoFar : 4'd0};
    vert_c.ao_v        = {ao_id[7:4], dv ? vfm_pkg::AoFar : 4'd0};
    vert_c.tex_u       = 4'd0;
    vert_c.tex_v       = 4'd0;
    if (cfg_i.textures_on) begin
      if (cfg_i.multi_texture_on) begin
        vert_c.tex_u = {1'b0, job_q.tile_x} + (dv ? 4'd0 : 4'd1);
        vert_c.tex_v = {1'b0, job_q.tile_y} + {3'b000, du};
      end else begin
        vert_c.tex_u = dv ? 4'd0 : vfm_pkg::TexFull;
        vert_c.tex_v = du ? vfm_pkg::TexFull : 4'd0;
      end
    end
    vert_c.last        = (k_q == 2'd3) && (rem_left == 6'd0);
  end

  assign adv = ~out_valid_q | vert.ready;

  always_comb begin
    job_d       = job_q;
    out_d       = out_q;
    rem_d       = rem_q;
    k_d         = k_q;
    act_d       = act_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (adv) begin
      out_valid_d = act_q;
      if (act_q) begin
        out_d = vert_c;
        if (k_q == 2'd3) begin
          k_d   = 2'd0;
          rem_d = rem_left;
          act_d = (rem_left != 6'd0);
        end else begin
          k_d = k_q + 2'd1;
        end
      end
    end
    if (!act_d && job_valid_i) begin
      job_d = job_i;
      rem_d = job_i.open;
      k_d   = 2'd0;
      act_d = 1'b1;
      pop_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      k_q         <= '0;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      k_q         <= k_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign vert.valid       = out_valid_q;
  assign vert.corner_x    = out_q.corner_x;
  assign vert.corner_y    = out_q.corner_y;
  assign vert.corner_z    = out_q.corner_z;
  assign vert.fixed_pos   = out_q.fixed_pos;
  assign vert.shade_color = out_q.shade_color;
  assign vert.shading     = out_q.shading;
  assign vert.face        = out_q.face;
  assign vert.ao_u        = out_q.ao_u;
  assign vert.ao_v        = out_q.ao_v;
  assign vert.tex_u       = out_q.tex_u;
  assign vert.tex_v       = out_q.tex_v;
  assign vert.last        = out_q.last;

endmodule
`default_nettype wire

[hw/rtl/voxel_face_mesher_with_ao.sv]
// Top level of the voxel face mesher with ambient occlusion.
`timescale 1ns / 1ps
`default_nettype none
// The first vertex word of a voxel passes through the job queue, the generator's job register
// and its output register. The vertex generator emits one word per cycle while the sink is
// ready; a voxel with n open faces gives 4n words (24 at most), and a voxel with no open
// face is culled. Voxel words are accepted every cycle while the two-entry job queue has room.
// Reset clears both texture registers, the queue and the generator; no clearing pass.
module voxel_face_mesher_with_ao #(
  parameter int ChunkSize  = vfm_pkg::ChunkSizeDef,
  parameter int QueueDepth = vfm_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  vfm_vox_if.sink    vox_i,
  vfm_vert_if.source vert_o
);

  vfm_pkg::cfg_t cfg_q, cfg_d;
  vfm_pkg::job_t push_job, head_job;
  logic          push, full, head_valid, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (vfm_pkg::reg_idx_e'(cfg_idx_i))
        vfm_pkg::RegTexturesOn:     cfg_d.textures_on      = cfg_data_i[0];
        vfm_pkg::RegMultiTextureOn: cfg_d.multi_texture_on = cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vfm_front #(
    .ChunkSize(ChunkSize)
  ) u_front (
    .vox    (vox_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  vfm_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (full),
    .valid_o (head_valid),
    .rdata_o (head_job),
    .pop_i   (pop)
  );

  vfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .vert        (vert_o)
  );

endmodule
`default_nettype wire

[hw/rtl/vfm_checker.sv]
// Port-level checker for the voxel face mesher and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_face_mesher_with_ao_macros.svh"
module vfm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [4:0] corner_x_i,
  input logic [7:0] shading_i,
  input logic [2:0] face_i,
  input logic [7:0] ao_u_i,
  input logic [7:0] ao_v_i,
  input logic [3:0] tex_u_i,
  input logic       last_i
);

  `VFM_ASSERT_NEXT(a_vert_hold, valid_i && !ready_i, valid_i && $stable(last_i) && $stable(face_i) && $stable(corner_x_i) && $stable(ao_u_i), "stalled vertex word changed")
  `VFM_ASSERT_IMPLY(a_face_range, valid_i, face_i <= vfm_pkg::FacePosY, "face code out of range")
  `VFM_ASSERT_IMPLY(a_shading, valid_i && face_i != vfm_pkg::FaceNegZ && face_i != vfm_pkg::FaceNegY, shading_i == 8'd0, "unexpected shading on lit face")
  `VFM_ASSERT_IMPLY(a_last_corner, valid_i && last_i, ao_u_i[3:0] == vfm_pkg::AoFar && ao_v_i[3:0] == vfm_pkg::AoFar && tex_u_i <= vfm_pkg::TexFull, "last word is not a far corner")

endmodule

bind voxel_face_mesher_with_ao vfm_checker u_vfm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (vert_o.valid),
  .ready_i    (vert_o.ready),
  .corner_x_i (vert_o.corner_x),
  .shading_i  (vert_o.shading),
  .face_i     (vert_o.face),
  .ao_u_i     (vert_o.ao_u),
  .ao_v_i     (vert_o.ao_v),
  .tex_u_i    (vert_o.tex_u),
  .last_i     (vert_o.last)
);
`default_nettype wire
